### rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define UED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UED_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define UED_ASSERT(label, prop, msg)
`define UED_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### rtl/core/ued_pkg.sv
`default_nettype none

package ued_pkg;

  localparam int UnitW = 16;

  localparam logic [UnitW-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [UnitW-1:0] CH_U         = 16'h0075;
  localparam logic [UnitW-1:0] CH_T         = 16'h0074;
  localparam logic [UnitW-1:0] CH_R         = 16'h0072;
  localparam logic [UnitW-1:0] CH_N         = 16'h006E;
  localparam logic [UnitW-1:0] CH_F         = 16'h0066;
  localparam logic [UnitW-1:0] CH_0         = 16'h0030;
  localparam logic [UnitW-1:0] CH_9         = 16'h0039;
  localparam logic [UnitW-1:0] CH_LA        = 16'h0061;
  localparam logic [UnitW-1:0] CH_LF        = 16'h0066;
  localparam logic [UnitW-1:0] CH_UA        = 16'h0041;
  localparam logic [UnitW-1:0] CH_UF        = 16'h0046;

  localparam logic [UnitW-1:0] CH_TAB = 16'h0009;
  localparam logic [UnitW-1:0] CH_CR  = 16'h000D;
  localparam logic [UnitW-1:0] CH_LFD = 16'h000A;
  localparam logic [UnitW-1:0] CH_FF  = 16'h000C;

  localparam logic [1:0] LAST_DIGIT = 2'd3;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX   = 2'd2
  } phase_t;

  typedef struct packed {
    logic             char_valid;
    logic [UnitW-1:0] decoded_unit;
    logic             text_done;
  } res_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
  } hex_t;

  function automatic hex_t hex_value(input logic [UnitW-1:0] c);
    hex_t h;
    logic [UnitW-1:0] off;
    h.is_hex = 1'b1;
    off = '0;
    if (c inside {[CH_0:CH_9]}) begin
      off = c - CH_0;
    end else if (c inside {[CH_LA:CH_LF]}) begin
      off = c - CH_LA + 16'd10;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      off = c - CH_UA + 16'd10;
    end else begin
      h.is_hex = 1'b0;
    end
    h.digit = off[3:0];
    return h;
  endfunction

  function automatic logic [UnitW-1:0] escape_map(input logic [UnitW-1:0] c);
    logic [UnitW-1:0] m;
    case (c)
      CH_T:    m = CH_TAB;
      CH_R:    m = CH_CR;
      CH_N:    m = CH_LFD;
      CH_F:    m = CH_FF;
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ued_decode.sv
`default_nettype none

`include "assert_macros.svh"

module ued_decode import ued_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [UnitW-1:0] code_unit,
  input  wire logic             end_of_text,
  output res_t                  res
);

  phase_t           phase_r, phase_nxt;
  logic [1:0]       digits_r, digits_nxt;
  logic [UnitW-1:0] acc_r, acc_nxt;
  logic [UnitW-1:0] acc_sh;
  hex_t             hv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PLAIN;
      digits_r <= '0;
      acc_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      digits_r <= digits_nxt;
      acc_r    <= acc_nxt;
    end
  end

  always_comb begin
    hv  = hex_value(code_unit);
    // non-digit units count toward the four but leave the value alone
    acc_sh = hv.is_hex ? {acc_r[UnitW-5:0], hv.digit} : acc_r;

    phase_nxt        = phase_r;
    digits_nxt       = digits_r;
    acc_nxt          = acc_r;
    res.char_valid   = 1'b0;
    res.decoded_unit = '0;
    res.text_done    = end_of_text;

    case (phase_r)
      PH_ESC: begin
        if (code_unit == CH_U) begin
          phase_nxt  = PH_HEX;
          digits_nxt = '0;
          acc_nxt    = '0;
        end else begin
          res.char_valid   = 1'b1;
          res.decoded_unit = escape_map(code_unit);
          phase_nxt        = PH_PLAIN;
        end
      end
      PH_HEX: begin
        if (digits_r == LAST_DIGIT) begin
          res.char_valid   = 1'b1;
          res.decoded_unit = acc_sh;
          phase_nxt        = PH_PLAIN;
          digits_nxt       = '0;
          acc_nxt          = '0;
        end else begin
          digits_nxt = digits_r + 2'd1;
          acc_nxt    = acc_sh;
        end
      end
      default: begin
        if (code_unit == CH_BACKSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          res.char_valid   = 1'b1;
          res.decoded_unit = code_unit;
          phase_nxt        = PH_PLAIN;
        end
      end
    endcase

    // end of text drops any pending escape
    if (end_of_text) begin
      phase_nxt  = PH_PLAIN;
      digits_nxt = '0;
      acc_nxt    = '0;
    end
  end

  `UED_ASSERT(a_digits_only_in_hex, (digits_r == 2'd0) || (phase_r == PH_HEX), "digit count outside hex escape")
  `UED_ASSERT(a_acc_clear_outside_hex, (acc_r == '0) || (phase_r == PH_HEX), "stale hex value outside escape")
  `UED_ASSERT_NEXT(a_eot_resets, step && end_of_text, (phase_r == PH_PLAIN) && (digits_r == 2'd0) && (acc_r == '0), "state not cleared after end of text")
  `UED_ASSERT_NEXT(a_hold_when_idle, !step, $stable(phase_r) && $stable(digits_r) && $stable(acc_r), "decode state moved without a request")
  `UED_ASSERT(a_fourth_unit_emits, !((phase_r == PH_HEX) && (digits_r == LAST_DIGIT)) || res.char_valid, "hex escape closed without output")

endmodule

`default_nettype wire

### rtl/core/unicode_escape_decoder.sv
// channel  ports                                   handshake
// input    in_code_unit[15:0], in_end_of_text       in_valid / in_ready
// output   out_char_valid, out_decoded_unit[15:0],  out_valid / out_ready
//          out_text_done
//
// one request per cycle sustained while out_ready stays high; each result reaches the outputs
// through the input register, then the result register
// the decode step between the two registers is a few compares and a 4-bit shift
// rst_n is synchronous; it empties both registers and returns to plain text
// a stall on the output holds the result register and then the input
// register, so in_ready falls only when both are full and out_ready is low
`default_nettype none

module unicode_escape_decoder import ued_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [UnitW-1:0] in_code_unit,
  input  wire logic             in_end_of_text,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_char_valid,
  output logic [UnitW-1:0]      out_decoded_unit,
  output logic                  out_text_done
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [UnitW-1:0] s1_unit_r;
  logic             s1_eot_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;
  res_t             dec_res;
  logic             out_can, s1_go, in_take;

  assign out_can  = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_can;
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_unit_r <= in_code_unit;
      s1_eot_r  <= in_end_of_text;
    end
    if (s1_go) begin
      out_res_r <= dec_res;
    end
  end

  ued_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_go),
    .code_unit   (s1_unit_r),
    .end_of_text (s1_eot_r),
    .res         (dec_res)
  );

  assign out_valid        = out_valid_r;
  assign out_char_valid   = out_res_r.char_valid;
  assign out_decoded_unit = out_res_r.decoded_unit;
  assign out_text_done    = out_res_r.text_done;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ued_pkg::*;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             eot;
  } text_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [UnitW-1:0] in_code_unit = '0;
  logic             in_end_of_text = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_char_valid;
  logic [UnitW-1:0] out_decoded_unit;
  logic             out_text_done;

  text_req_t pending_units[$];
  res_t      decoded_expect[$];

  // decoder state as the testbench sees it
  phase_t           dec_phase = PH_PLAIN;
  logic [1:0]       dec_digits = '0;
  logic [UnitW-1:0] dec_acc = '0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int queued_count = 0;
  bit pressure_go = 1'b0;
  bit hold_off = 1'b0;

  unicode_escape_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_unit     (in_code_unit),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_valid   (out_char_valid),
    .out_decoded_unit (out_decoded_unit),
    .out_text_done    (out_text_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic res_t decode_unit(input logic [UnitW-1:0] c, input logic eot);
    res_t       r;
    logic       is_hex;
    logic [3:0] d;
    r = '0;
    r.text_done = eot;
    is_hex = 1'b1;
    d = '0;
    case (dec_phase)
      PH_ESC: begin
        if (c == CH_U) begin
          dec_phase = PH_HEX;
          dec_digits = '0;
          dec_acc = '0;
        end else begin
          r.char_valid = 1'b1;
          case (c)
            CH_T:    r.decoded_unit = CH_TAB;
            CH_R:    r.decoded_unit = CH_CR;
            CH_N:    r.decoded_unit = CH_LFD;
            CH_F:    r.decoded_unit = CH_FF;
            default: r.decoded_unit = c;
          endcase
          dec_phase = PH_PLAIN;
        end
      end
      PH_HEX: begin
        if (c >= CH_0 && c <= CH_9) begin
          d = 4'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
          d = 4'(c - CH_LA + 16'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
          d = 4'(c - CH_UA + 16'd10);
        end else begin
          is_hex = 1'b0;
        end
        // a non-digit still uses up one of the four slots
        if (is_hex) dec_acc = {dec_acc[UnitW-5:0], d};
        if (dec_digits == LAST_DIGIT) begin
          r.char_valid = 1'b1;
          r.decoded_unit = dec_acc;
          dec_phase = PH_PLAIN;
          dec_digits = '0;
          dec_acc = '0;
        end else begin
          dec_digits = dec_digits + 2'd1;
        end
      end
      default: begin
        if (c == CH_BACKSLASH) begin
          dec_phase = PH_ESC;
        end else begin
          r.char_valid = 1'b1;
          r.decoded_unit = c;
          dec_phase = PH_PLAIN;
        end
      end
    endcase
    if (eot) begin
      dec_phase = PH_PLAIN;
      dec_digits = '0;
      dec_acc = '0;
    end
    return r;
  endfunction

  task automatic push_unit(input logic [UnitW-1:0] unit, input logic eot);
    text_req_t item;
    item.unit = unit;
    item.eot = eot;
    pending_units.push_back(item);
    queued_count++;
  endtask

  // random end marks break escapes now and then
  task automatic push_rand_unit(input logic [UnitW-1:0] unit);
    push_unit(unit, $urandom_range(0, 29) == 0);
  endtask

  task automatic queue_random_text(input int n_units);
    int target;
    int kind;
    int idx;
    target = queued_count + n_units;
    while (queued_count < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 1) == 0) push_rand_unit(UnitW'($urandom_range(0, 65535)));
        else push_rand_unit(UnitW'($urandom_range(32'h20, 32'h7e)));
      end else if (kind < 50) begin
        push_rand_unit(CH_BACKSLASH);
        case ($urandom_range(0, 5))
          0: push_rand_unit(CH_T);
          1: push_rand_unit(CH_R);
          2: push_rand_unit(CH_N);
          3: push_rand_unit(CH_F);
          4: push_rand_unit(UnitW'($urandom_range(0, 65535)));
          default: push_rand_unit(UnitW'($urandom_range(32'h20, 32'h7e)));
        endcase
      end else begin
        push_rand_unit(CH_BACKSLASH);
        push_rand_unit(CH_U);
        repeat (4) begin
          idx = $urandom_range(0, 21);
          if ($urandom_range(0, 4) == 0) push_rand_unit(UnitW'($urandom_range(0, 65535)));
          else if (idx < 10) push_rand_unit(CH_0 + UnitW'(idx));
          else if (idx < 16) push_rand_unit(CH_LA + UnitW'(idx - 10));
          else push_rand_unit(CH_UA + UnitW'(idx - 16));
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_units.size() != 0 || in_valid || decoded_expect.size() != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_units);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    queue_random_text(n_units);
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin
    text_req_t item;
    bit        busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        decoded_expect.push_back(decode_unit(in_code_unit, in_end_of_text));
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_units.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          item = pending_units.pop_front();
          in_code_unit <= item.unit;
          in_end_of_text <= item.eot;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_expect.size() == 0) begin
        $display("%0t: result with nothing pending: valid=%0b unit=%h done=%0b", $realtime,
                 out_char_valid, out_decoded_unit, out_text_done);
        error_count++;
      end else begin
        want = decoded_expect.pop_front();
        if (out_char_valid !== want.char_valid) begin
          $display("%0t: char_valid expected %0b actual %0b", $realtime, want.char_valid,
                   out_char_valid);
          error_count++;
        end
        if (out_decoded_unit !== want.decoded_unit) begin
          $display("%0t: decoded_unit expected %h actual %h", $realtime, want.decoded_unit,
                   out_decoded_unit);
          error_count++;
        end
        if (out_text_done !== want.text_done) begin
          $display("%0t: text_done expected %0b actual %0b", $realtime, want.text_done,
                   out_text_done);
          error_count++;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and drops in_ready
  initial begin
    wait (pressure_go);
    repeat (20) @(negedge clk);
    hold_off = 1'b1;
    repeat (160) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    // plain extremes
    push_unit(16'h0000, 1'b0);
    push_unit(16'hFFFF, 1'b0);
    // the four named escapes, one ending the text
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_T, 1'b0);
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_R, 1'b0);
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_N, 1'b1);
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_F, 1'b0);
    // escaped backslash passes as itself
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_BACKSLASH, 1'b0);
    // hex escape with mixed case and a unit above 0xff that is skipped
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_U, 1'b0);
    push_unit(CH_9, 1'b0);
    push_unit(CH_LA, 1'b0);
    push_unit(CH_UF, 1'b0);
    push_unit(16'h0130, 1'b0);
    // non-digits just outside the digit ranges, last unit ends the text
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_U, 1'b0);
    push_unit(CH_UF + 16'd1, 1'b0);
    push_unit(CH_0 - 16'd1, 1'b0);
    push_unit(CH_LF, 1'b0);
    push_unit(CH_UA, 1'b1);
    // hex escape cut short by end of text
    push_unit(CH_BACKSLASH, 1'b0);
    push_unit(CH_U, 1'b0);
    push_unit(CH_0, 1'b1);
    // pending backslash dropped at end of text
    push_unit(CH_BACKSLASH, 1'b1);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    pressure_go = 1'b1;
    run_phase(0, 0, 350);
    run_phase(48, 0, 350);
    run_phase(0, 48, 350);
    run_phase(32, 32, 350);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
